// ----- hdl/xvd_pkg.sv -----
package xvd_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned KEY_WORDS = 4;
  localparam int unsigned CFG_IDX_W = 4;

  localparam logic [WORD_W-1:0] DELTA = 32'h61C8_8647;

  typedef logic [KEY_WORDS-1:0][WORD_W-1:0] key_t;

  // Reset keys: ASCII "Rirn53a;feb#UXES" and "5ZrRBTGmYwml:fRt", little-endian words
  localparam key_t KEY_A_RST = {32'h5345_5855, 32'h2362_6566, 32'h3B61_3335, 32'h6E72_6952};
  localparam key_t KEY_B_RST = {32'h7452_663A, 32'h6C6D_7759, 32'h6D47_5442, 32'h5272_5A35};

  typedef enum logic [CFG_IDX_W-1:0] {
    KEY_A_W0 = 4'd0,
    KEY_A_W1 = 4'd1,
    KEY_A_W2 = 4'd2,
    KEY_A_W3 = 4'd3,
    KEY_B_W0 = 4'd4,
    KEY_B_W1 = 4'd5,
    KEY_B_W2 = 4'd6,
    KEY_B_W3 = 4'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [WORD_W-1:0] lo;
    logic [WORD_W-1:0] hi;
    logic              last;
  } blk_t;

  // Running sum at the start of round r: DELTA * (r - rounds) mod 2^32
  function automatic logic [WORD_W-1:0] round_sum(input int unsigned r,
                                                  input int unsigned rounds);
    logic [WORD_W-1:0] n;
    n = WORD_W'(r) - WORD_W'(rounds);
    return WORD_W'(DELTA * n);
  endfunction

  function automatic logic [WORD_W-1:0] mix(input logic [WORD_W-1:0] v);
    return (v << 4) ^ (v >> 5);
  endfunction

endpackage

// ----- hdl/xvd_in_if.sv -----
interface xvd_in_if;
  logic                       valid;
  logic                       ready;
  logic [xvd_pkg::WORD_W-1:0] cipher_low;
  logic [xvd_pkg::WORD_W-1:0] cipher_high;
  logic                       last_in;

  modport source (output valid, output cipher_low, output cipher_high, output last_in,
                  input ready);
  modport sink   (input valid, input cipher_low, input cipher_high, input last_in,
                  output ready);
endinterface

// ----- hdl/xvd_out_if.sv -----
interface xvd_out_if;
  logic                       valid;
  logic                       ready;
  logic [xvd_pkg::WORD_W-1:0] plain_low;
  logic [xvd_pkg::WORD_W-1:0] plain_high;
  logic                       last_out;

  modport source (output valid, output plain_low, output plain_high, output last_out,
                  input ready);
  modport sink   (input valid, input plain_low, input plain_high, input last_out,
                  output ready);
endinterface

// ----- hdl/xvd_round.sv -----
module xvd_round #(
  parameter logic [31:0] SUM = 32'h0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  xvd_pkg::key_t key_i,
  input  logic          vld_i,
  input  xvd_pkg::blk_t blk_i,
  output logic          vld_o,
  output xvd_pkg::blk_t blk_o
);
  import xvd_pkg::*;

  localparam logic [WORD_W-1:0] SUM2 = SUM + DELTA;
  localparam logic [1:0]        KI1  = SUM[12:11];
  localparam logic [1:0]        KI2  = SUM2[1:0];

  logic vld1_q, vld2_q;
  blk_t half_d, half_q, full_d, full_q;

  // first half: update the high word
  always_comb begin
    half_d    = blk_i;
    half_d.hi = blk_i.hi - (mix(blk_i.lo) + (key_i[KI1] + (blk_i.lo ^ SUM)));
  end

  // second half: update the low word with the stepped sum
  always_comb begin
    full_d    = half_q;
    full_d.lo = half_q.lo - ((key_i[KI2] + (half_q.hi ^ SUM2)) + mix(half_q.hi));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= vld_i;
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      half_q <= half_d;
      full_q <= full_d;
    end
  end

  assign vld_o = vld2_q;
  assign blk_o = full_q;

endmodule

// ----- hdl/xvd_pipe.sv -----
module xvd_pipe #(
  parameter int unsigned ROUNDS = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  xvd_pkg::key_t key_i,
  input  logic          vld_i,
  input  xvd_pkg::blk_t blk_i,
  output logic          vld_o,
  output xvd_pkg::blk_t blk_o
);
  import xvd_pkg::*;

  logic [ROUNDS:0] vld;
  blk_t            blk [ROUNDS+1];

  assign vld[0] = vld_i;
  assign blk[0] = blk_i;

  for (genvar r = 0; r < ROUNDS; r++) begin : g_round
    xvd_round #(
      .SUM (round_sum(r, ROUNDS))
    ) u_round (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en_i),
      .key_i  (key_i),
      .vld_i  (vld[r]),
      .blk_i  (blk[r]),
      .vld_o  (vld[r+1]),
      .blk_o  (blk[r+1])
    );
  end

  assign vld_o = vld[ROUNDS];
  assign blk_o = blk[ROUNDS];

endmodule

// ----- hdl/xvd_skid.sv -----
module xvd_skid (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          vld_i,
  input  xvd_pkg::blk_t blk_i,
  output logic          en_o,
  output logic          vld_o,
  output xvd_pkg::blk_t blk_o,
  input  logic          ready_i
);
  import xvd_pkg::*;

  logic out_vld_q, skid_vld_q;
  blk_t out_q, skid_q;
  logic slot_free;

  assign en_o      = !skid_vld_q;
  assign slot_free = !out_vld_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (slot_free) begin
      out_vld_q  <= skid_vld_q || vld_i;
      skid_vld_q <= 1'b0;
    end else if (vld_i && !skid_vld_q) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_free) begin
      out_q <= skid_vld_q ? skid_q : blk_i;
    end else if (vld_i && !skid_vld_q) begin
      skid_q <= blk_i;
    end
  end

  assign vld_o = out_vld_q;
  assign blk_o = out_q;

endmodule

// ----- hdl/xtea_variant_double_block_decrypt_core.sv -----
// Double-key XTEA-variant block decrypter, ECB, fully pipelined.
// in_req  : valid/ready request carrying one 64-bit ciphertext block as two
//           little-endian words plus a last flag that rides along unchanged.
// out_req : valid/ready request with the plaintext words and the last flag.
// cfg     : write-only key port, index 0..3 key A words, 4..7 key B words;
//           other indexes are dropped. The user must change keys only while
//           idle; the block itself does not enforce this.
// Each round is split into two register stages (high half, low half), so
// the datapath is 4*ROUNDS stages deep: ROUNDS with key A, then ROUNDS with
// key B. Per stage the logic is one four-operand 32-bit add/subtract chain.
// One block per cycle is accepted until a receiver stall fills the skid
// buffer. Reset clears all valid bits and loads the built-in keys; no pass
// needed. Receiver stall: the output register holds the result and a
// one-entry skid buffer catches the next block, after which the whole
// pipeline freezes and in_req.ready drops; nothing is lost or repeated.
// Ready returns the cycle after the receiver takes a result.
module xtea_variant_double_block_decrypt_core #(
  parameter int unsigned ROUNDS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  xvd_in_if.sink                        in_req,
  xvd_out_if.source                     out_req,
  input  logic                          cfg_we_i,
  input  logic [xvd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [xvd_pkg::WORD_W-1:0]    cfg_data_i
);
  import xvd_pkg::*;

  key_t key_a_q, key_b_q;

  logic en;
  logic vld_a, vld_b;
  blk_t blk_in, blk_a, blk_b, blk_out;
  logic vld_out;

  // Key registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_a_q <= KEY_A_RST;
      key_b_q <= KEY_B_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        KEY_A_W0: key_a_q[0] <= cfg_data_i;
        KEY_A_W1: key_a_q[1] <= cfg_data_i;
        KEY_A_W2: key_a_q[2] <= cfg_data_i;
        KEY_A_W3: key_a_q[3] <= cfg_data_i;
        KEY_B_W0: key_b_q[0] <= cfg_data_i;
        KEY_B_W1: key_b_q[1] <= cfg_data_i;
        KEY_B_W2: key_b_q[2] <= cfg_data_i;
        KEY_B_W3: key_b_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign blk_in.lo   = in_req.cipher_low;
  assign blk_in.hi   = in_req.cipher_high;
  assign blk_in.last = in_req.last_in;

  // Whole pipeline advances together; held only when the skid entry is full
  assign in_req.ready = en;

  xvd_pipe #(.ROUNDS(ROUNDS)) u_pipe_a (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .key_i  (key_a_q),
    .vld_i  (in_req.valid),
    .blk_i  (blk_in),
    .vld_o  (vld_a),
    .blk_o  (blk_a)
  );

  xvd_pipe #(.ROUNDS(ROUNDS)) u_pipe_b (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .key_i  (key_b_q),
    .vld_i  (vld_a),
    .blk_i  (blk_a),
    .vld_o  (vld_b),
    .blk_o  (blk_b)
  );

  xvd_skid u_skid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vld_i   (vld_b),
    .blk_i   (blk_b),
    .en_o    (en),
    .vld_o   (vld_out),
    .blk_o   (blk_out),
    .ready_i (out_req.ready)
  );

  assign out_req.valid      = vld_out;
  assign out_req.plain_low  = blk_out.lo;
  assign out_req.plain_high = blk_out.hi;
  assign out_req.last_out   = blk_out.last;

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

// Block-level bench for the double-key XTEA-variant decrypter.
// Ciphertext requests come from a queue that the sequencer below fills.
// Every accepted request is run through a behavioral copy of the cipher,
// using the bench's own shadow of the key registers. The expected plaintext
// is queued in order and then matched against the results on the output
// channel. Backpressure is random on both sides.
module testbench;

  import xvd_pkg::*;

  localparam int unsigned ROUNDS      = 32;
  localparam int unsigned CLK_HALF_NS = 2;
  localparam int unsigned RST_CYCLES  = 10;
  // Pipeline depth from the core header plus some slack for the tail check.
  localparam int unsigned DRAIN_CYCLES = 4 * ROUNDS + 1 + 64;
  // Worst case is roughly 520 blocks, each waiting out the sender gap and the
  // receiver stall, plus a full pipeline flush at every drain point.
  localparam int unsigned TIMEOUT_NS = 2_000_000;
  localparam int unsigned RANDOM_PER_PHASE = 167;

  localparam logic [WORD_W-1:0] SUM_STEP = 32'h61C8_8647;
  // First index past the key map. The core must drop writes at this index and above.
  localparam logic [CFG_IDX_W-1:0] FIRST_UNUSED_IDX = CFG_IDX_W'(KEY_B_W3 + 1);

  typedef logic [WORD_W-1:0] word_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  word_t                cfg_data_i;

  xvd_in_if  in_if ();
  xvd_out_if out_if ();

  xtea_variant_double_block_decrypt_core #(
    .ROUNDS (ROUNDS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_req     (in_if),
    .out_req    (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Shadow copy of the key registers. It is updated as the writes go out,
  // and the core is idle whenever that happens.
  key_t key_a_shadow;
  key_t key_b_shadow;

  blk_t cipher_pending[$];   // ciphertext requests not yet accepted
  blk_t plain_expected[$];   // predicted plaintext, oldest first

  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned n_accepted;
  int unsigned n_last_flag;
  int unsigned n_results;
  int unsigned n_key_sets;
  int unsigned n_errors;

  // ---------------------------------------------------------------------------
  // Cipher prediction
  // ---------------------------------------------------------------------------

  // One full decrypt over ROUNDS rounds with key k. The running sum walks from
  // step * (-ROUNDS) up to zero.
  function automatic void decrypt_pass(input key_t k, inout word_t v0, inout word_t v1);
    word_t s;
    s = SUM_STEP * (word_t'(0) - word_t'(ROUNDS));
    for (int r = 0; r < ROUNDS; r++) begin
      v1 = v1 - (((v0 << 4) ^ (v0 >> 5)) + (k[s[12:11]] + (v0 ^ s)));
      s  = s + SUM_STEP;
      v0 = v0 - ((k[s[1:0]] + (v1 ^ s)) + ((v1 << 4) ^ (v1 >> 5)));
    end
  endfunction

  // Key A first, then key B. The last flag rides through unchanged.
  function automatic blk_t plain_of(input blk_t c);
    word_t v0;
    word_t v1;
    blk_t  p;
    v0 = c.lo;
    v1 = c.hi;
    decrypt_pass(key_a_shadow, v0, v1);
    decrypt_pass(key_b_shadow, v0, v1);
    p.lo   = v0;
    p.hi   = v1;
    p.last = c.last;
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, limit
  // ---------------------------------------------------------------------------

  initial begin
    clk_i = 1'b0;
    forever #(CLK_HALF_NS) clk_i = ~clk_i;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("TIMEOUT: %0d results seen, %0d still expected", n_results,
             plain_expected.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver: present the head of cipher_pending, hold it until accepted.
  // ---------------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid       <= 1'b0;
      in_if.cipher_low  <= '0;
      in_if.cipher_high <= '0;
      in_if.last_in     <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        // Keys cannot change while requests are in flight, so predict now.
        plain_expected.push_back(plain_of(cipher_pending.pop_front()));
        n_accepted++;
        if (in_if.last_in) n_last_flag++;
      end
      if (in_if.valid && !in_if.ready) begin
        // stalled: the request stays on the bus as it is
      end else if (cipher_pending.size() != 0 &&
                   $urandom_range(0, 99) >= tx_idle_pct) begin
        in_if.valid       <= 1'b1;
        in_if.cipher_low  <= cipher_pending[0].lo;
        in_if.cipher_high <= cipher_pending[0].hi;
        in_if.last_in     <= cipher_pending[0].last;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random ready, in-order compare against plain_expected.
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input word_t got, input word_t want);
    $display("ERROR @%0t: %s got %08h, want %08h (result %0d)", $realtime, what, got,
             want, n_results);
    n_errors++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (plain_expected.size() == 0) begin
          report_mismatch("unexpected result, plain_low", out_if.plain_low, '0);
        end else begin
          if (out_if.plain_low !== plain_expected[0].lo)
            report_mismatch("plain_low", out_if.plain_low, plain_expected[0].lo);
          if (out_if.plain_high !== plain_expected[0].hi)
            report_mismatch("plain_high", out_if.plain_high, plain_expected[0].hi);
          if (out_if.last_out !== plain_expected[0].last)
            report_mismatch("last_out", word_t'(out_if.last_out),
                            word_t'(plain_expected[0].last));
          void'(plain_expected.pop_front());
        end
        n_results++;
      end
      out_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer helpers
  // ---------------------------------------------------------------------------

  task automatic queue_block(input word_t lo, input word_t hi, input logic last);
    blk_t b;
    b.lo   = lo;
    b.hi   = hi;
    b.last = last;
    cipher_pending.push_back(b);
  endtask

  // Mostly random words with an occasional last flag. About one block in
  // sixteen is a zero-padded tail of 1..7 bytes, which always carries last.
  function automatic blk_t random_block();
    blk_t        b;
    int unsigned nbytes;
    logic [63:0] keep;
    b.lo   = $urandom;
    b.hi   = $urandom;
    b.last = ($urandom_range(0, 7) == 0);
    if ($urandom_range(0, 15) == 0) begin
      nbytes      = $urandom_range(1, 7);
      keep        = (64'd1 << (8 * nbytes)) - 64'd1;
      {b.hi, b.lo} = {b.hi, b.lo} & keep;
      b.last      = 1'b1;
    end
    return b;
  endfunction

  // Quiet point: nothing pending, nothing on the bus, every result back.
  task automatic wait_drained();
    @(negedge clk_i);
    while (cipher_pending.size() != 0 || in_if.valid || plain_expected.size() != 0)
      @(negedge clk_i);
  endtask

  // One register per cycle. Shadow keys follow the write; an index past the
  // key map must leave both keys untouched.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input word_t data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    if (idx <= KEY_A_W3)
      key_a_shadow[idx - KEY_A_W0] = data;
    else if (idx <= KEY_B_W3)
      key_b_shadow[idx - KEY_B_W0] = data;
  endtask

  task automatic end_writes();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Walk the whole key map by name: A words 0..3, then B words 0..3.
  task automatic load_keys(input key_t ka, input key_t kb);
    cfg_idx_e r;
    r = r.first();
    do begin
      write_reg(r, (r <= KEY_A_W3) ? ka[r - KEY_A_W0] : kb[r - KEY_B_W0]);
      r = r.next();
    end while (r != r.first());
    end_writes();
    n_key_sets++;
  endtask

  function automatic key_t random_key();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  // Random section under one flow-control mode, with fresh keys. The sender
  // stops at the midpoint until the pipeline has fully drained.
  task automatic random_phase(input int unsigned tx_pct, input int unsigned rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    load_keys(random_key(), random_key());
    @(negedge clk_i);
    for (int i = 0; i < RANDOM_PER_PHASE / 2; i++) cipher_pending.push_back(random_block());
    wait_drained();
    for (int i = RANDOM_PER_PHASE / 2; i < RANDOM_PER_PHASE; i++)
      cipher_pending.push_back(random_block());
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    // Drive every input from time zero. Reset is asserted once and never again.
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = '0;
    cfg_data_i        = '0;
    in_if.valid       = 1'b0;
    in_if.cipher_low  = '0;
    in_if.cipher_high = '0;
    in_if.last_in     = 1'b0;
    out_if.ready      = 1'b0;
    tx_idle_pct       = 0;
    rx_idle_pct       = 0;
    n_accepted        = 0;
    n_last_flag       = 0;
    n_results         = 0;
    n_key_sets        = 1;
    n_errors          = 0;

    // Built-in keys: ASCII "Rirn53a;feb#UXES" and "5ZrRBTGmYwml:fRt" as LE words.
    key_a_shadow = {32'd1397053525, 32'd593651046, 32'd996225845, 32'd1852991826};
    key_b_shadow = {32'd1951557178, 32'd1819113305, 32'd1833391170, 32'd1383225909};

    repeat (RST_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed, reset keys, back to back: field extremes, alternating and
    // single-bit patterns, and zero-padded short tails.
    queue_block(32'h0000_0000, 32'h0000_0000, 1'b0);
    queue_block(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    queue_block(32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
    queue_block(32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
    queue_block(32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
    queue_block(32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
    queue_block(32'h8000_0000, 32'h0000_0001, 1'b0);
    queue_block(32'h0000_0001, 32'h8000_0000, 1'b1);
    queue_block(32'h0063_6261, 32'h0000_0000, 1'b1);   // 3-byte tail
    queue_block(32'h6463_6261, 32'h0000_0065, 1'b1);   // 5-byte tail
    wait_drained();

    // Writes past the key map must be dropped; the keys stay at their reset values.
    for (int i = int'(FIRST_UNUSED_IDX); i < 2 ** CFG_IDX_W; i++)
      write_reg(CFG_IDX_W'(i), $urandom);
    end_writes();
    @(negedge clk_i);
    queue_block(32'h0000_0000, 32'h0000_0000, 1'b0);
    queue_block(32'h1234_5678, 32'h9ABC_DEF0, 1'b1);
    wait_drained();

    // Key extremes: all zero, then all one.
    load_keys('0, '0);
    @(negedge clk_i);
    queue_block(32'h0000_0000, 32'h0000_0000, 1'b0);
    queue_block(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    queue_block($urandom, $urandom, 1'b0);
    wait_drained();

    load_keys('1, '1);
    @(negedge clk_i);
    queue_block(32'h0000_0000, 32'h0000_0000, 1'b1);
    queue_block(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    queue_block($urandom, $urandom, 1'b1);
    wait_drained();

    // Random: receiver-heavy stalls, then sender-heavy gaps, then full rate.
    random_phase(38, 64);
    random_phase(64, 38);
    random_phase(0, 0);

    // Tail: anything that still shows up after this point is a stray result.
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d blocks (%0d flagged last), %0d results, %0d key settings,",
             n_accepted, n_last_flag, n_results, n_key_sets);
    $display("dropped writes past the key map, and three flow-control modes.");
    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
